FILE: rtl/msc_pkg.sv
package msc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int CSIZE_WIDTH      = 31;
    localparam int MU_WIDTH         = 16;
    localparam int MAX_PRIMS        = 4;

    localparam logic [15:0] ISO_RESET  = 16'd0;
    localparam logic [30:0] SIZE_RESET = 31'd65536;

    // register indexes
    localparam logic [0:0] REG_ISO  = 1'b0;
    localparam logic [0:0] REG_SIZE = 1'b1;

    localparam logic KIND_TRI = 1'b0;
    localparam logic KIND_SEG = 1'b1;

    // point codes: 0..3 corners, 4..7 crossings on edges 01,12,23,30
    typedef logic [2:0] pt_code_t;
    localparam pt_code_t P_C0 = 3'd0;
    localparam pt_code_t P_C1 = 3'd1;
    localparam pt_code_t P_C2 = 3'd2;
    localparam pt_code_t P_C3 = 3'd3;
    localparam pt_code_t P_E01 = 3'd4;
    localparam pt_code_t P_E12 = 3'd5;
    localparam pt_code_t P_E23 = 3'd6;
    localparam pt_code_t P_E30 = 3'd7;

    typedef struct packed {
        logic     kind;
        pt_code_t pa;
        pt_code_t pb;
        pt_code_t pc;
    } prim_t;

    typedef struct packed {
        logic [2:0] count;
        prim_t [MAX_PRIMS-1:0] prims;
    } case_ent_t;

    function automatic prim_t tri_p(input pt_code_t a, input pt_code_t b, input pt_code_t c);
        tri_p = '{kind: KIND_TRI, pa: a, pb: b, pc: c};
    endfunction

    function automatic prim_t seg_p(input pt_code_t a, input pt_code_t b);
        seg_p = '{kind: KIND_SEG, pa: a, pb: b, pc: P_C0};
    endfunction

    // fixed triangle fan and contour table, entry k at prims[k]
    function automatic case_ent_t case_lookup(input logic [3:0] m);
        case_ent_t e;
        e = '0;
        case (m)
            4'd1: begin
                e.count = 3'd2;
                e.prims[0] = tri_p(P_C0, P_E01, P_E30);
                e.prims[1] = seg_p(P_E01, P_E30);
            end
            4'd2: begin
                e.count = 3'd2;
                e.prims[0] = tri_p(P_E01, P_C1, P_E12);
                e.prims[1] = seg_p(P_E01, P_E12);
            end
            4'd3: begin
                e.count = 3'd3;
                e.prims[0] = tri_p(P_C0, P_C1, P_E30);
                e.prims[1] = tri_p(P_E30, P_C1, P_E12);
                e.prims[2] = seg_p(P_E30, P_E12);
            end
            4'd4: begin
                e.count = 3'd2;
                e.prims[0] = tri_p(P_E12, P_C2, P_E23);
                e.prims[1] = seg_p(P_E12, P_E23);
            end
            4'd5: begin
                e.count = 3'd4;
                e.prims[0] = tri_p(P_C0, P_E01, P_E30);
                e.prims[1] = tri_p(P_E12, P_C2, P_E23);
                e.prims[2] = seg_p(P_E01, P_E30);
                e.prims[3] = seg_p(P_E12, P_E23);
            end
            4'd6: begin
                e.count = 3'd3;
                e.prims[0] = tri_p(P_E01, P_C1, P_E23);
                e.prims[1] = tri_p(P_E23, P_C1, P_C2);
                e.prims[2] = seg_p(P_E01, P_E23);
            end
            4'd7: begin
                e.count = 3'd4;
                e.prims[0] = tri_p(P_C0, P_C1, P_E30);
                e.prims[1] = tri_p(P_E30, P_C1, P_E23);
                e.prims[2] = tri_p(P_E23, P_C1, P_C2);
                e.prims[3] = seg_p(P_E30, P_E23);
            end
            4'd8: begin
                e.count = 3'd2;
                e.prims[0] = tri_p(P_E30, P_E23, P_C3);
                e.prims[1] = seg_p(P_E30, P_E23);
            end
            4'd9: begin
                e.count = 3'd3;
                e.prims[0] = tri_p(P_C0, P_E01, P_C3);
                e.prims[1] = tri_p(P_C3, P_E01, P_E23);
                e.prims[2] = seg_p(P_E01, P_E23);
            end
            4'd10: begin
                e.count = 3'd4;
                e.prims[0] = tri_p(P_E01, P_C1, P_E12);
                e.prims[1] = tri_p(P_E30, P_E23, P_C3);
                e.prims[2] = seg_p(P_E01, P_E12);
                e.prims[3] = seg_p(P_E30, P_E23);
            end
            4'd11: begin
                e.count = 3'd4;
                e.prims[0] = tri_p(P_C0, P_C1, P_E12);
                e.prims[1] = tri_p(P_C0, P_E12, P_E23);
                e.prims[2] = tri_p(P_C0, P_E23, P_C3);
                e.prims[3] = seg_p(P_E12, P_E23);
            end
            4'd12: begin
                e.count = 3'd3;
                e.prims[0] = tri_p(P_E30, P_E12, P_C3);
                e.prims[1] = tri_p(P_C3, P_E12, P_C2);
                e.prims[2] = seg_p(P_E30, P_E12);
            end
            4'd13: begin
                e.count = 3'd4;
                e.prims[0] = tri_p(P_C0, P_E01, P_C3);
                e.prims[1] = tri_p(P_C3, P_E01, P_E12);
                e.prims[2] = tri_p(P_C3, P_E12, P_C2);
                e.prims[3] = seg_p(P_E01, P_E12);
            end
            4'd14: begin
                e.count = 3'd4;
                e.prims[0] = tri_p(P_E01, P_C1, P_C2);
                e.prims[1] = tri_p(P_E01, P_C2, P_E30);
                e.prims[2] = tri_p(P_E30, P_C2, P_C3);
                e.prims[3] = seg_p(P_E01, P_E30);
            end
            4'd15: begin
                e.count = 3'd2;
                e.prims[0] = tri_p(P_C0, P_C1, P_C3);
                e.prims[1] = tri_p(P_C3, P_C1, P_C2);
            end
            default: e = '0;
        endcase
        case_lookup = e;
    endfunction

endpackage

FILE: rtl/msc_div.sv
// Pipelined restoring divider: q = floor(num * 2^16 / den), num < den.
// One quotient bit per stage, 16 stages; a sideband rides alongside.
module msc_div #(
    parameter int DW = 17,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [15:0]   quo,
    output logic [SW-1:0] side_out
);

    localparam int NST = msc_pkg::MU_WIDTH;

    logic [NST:0]         vld_reg;
    logic [DW:0]          rem_reg  [NST+1];
    logic [DW-1:0]        den_reg  [NST+1];
    logic [NST-1:0]       q_reg    [NST+1];
    logic [SW-1:0]        side_reg [NST+1];

    always_comb
    begin
        vld_reg[0]  = in_valid;
        rem_reg[0]  = {1'b0, num};
        den_reg[0]  = den;
        q_reg[0]    = '0;
        side_reg[0] = side_in;
    end

    genvar g;
    generate
        for (g = 0; g < NST; g++) begin : g_st
            logic [DW+1:0] sh;
            logic          ge;
            assign sh = {rem_reg[g], 1'b0};
            assign ge = sh >= {2'b00, den_reg[g]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g+1] <= 1'b0;
                else if (en)
                    vld_reg[g+1] <= vld_reg[g];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1]  <= ge ? (DW+1)'(sh - {2'b00, den_reg[g]}) : (DW+1)'(sh);
                    den_reg[g+1]  <= den_reg[g];
                    q_reg[g+1]    <= {q_reg[g][NST-2:0], ge};
                    side_reg[g+1] <= side_reg[g];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NST];
    assign quo       = q_reg[NST];
    assign side_out  = side_reg[NST];

endmodule

FILE: rtl/msc_seq.sv
// Primitive sequencer: holds one computed cell and emits its primitives,
// one per cycle unless stall holds a full output register, through an output register.
module msc_seq #(
    parameter int COORD_WIDTH = msc_pkg::COORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cell_valid,
    output logic                   cell_take,
    input  logic [3:0]             cell_mask,
    input  logic [COORD_WIDTH-1:0] pt_x [8],
    input  logic [COORD_WIDTH-1:0] pt_y [8],
    input  logic                   stall,
    output logic                   valid,
    output logic                   prim_kind,
    output logic [COORD_WIDTH-1:0] ax,
    output logic [COORD_WIDTH-1:0] ay,
    output logic [COORD_WIDTH-1:0] bx,
    output logic [COORD_WIDTH-1:0] by_coord,
    output logic [COORD_WIDTH-1:0] cx,
    output logic [COORD_WIDTH-1:0] cy,
    output logic                   last_prim
);

    msc_pkg::case_ent_t ent;
    msc_pkg::prim_t     pr;
    logic [1:0]         idx_reg, idx_next;
    logic               ovld_reg;
    logic               load;
    logic               is_last;
    logic               has_prims;

    assign ent       = msc_pkg::case_lookup(cell_mask);
    assign pr        = ent.prims[idx_reg];
    assign has_prims = ent.count != 3'd0;
    assign is_last   = ({1'b0, idx_reg} + 3'd1) == ent.count;
    assign load      = cell_valid && (!ovld_reg || !stall);
    // done with this cell after its last primitive loads, or at once if empty
    assign cell_take = cell_valid && (!has_prims || (load && is_last));
    assign idx_next  = cell_take ? 2'd0 : (load ? idx_reg + 2'd1 : idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load && has_prims)
                ovld_reg <= 1'b1;
            else if (!stall)
                ovld_reg <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (load && has_prims)
        begin
            prim_kind <= pr.kind;
            ax        <= pt_x[pr.pa];
            ay        <= pt_y[pr.pa];
            bx        <= pt_x[pr.pb];
            by_coord  <= pt_y[pr.pb];
            cx        <= (pr.kind == msc_pkg::KIND_TRI) ? pt_x[pr.pc] : '0;
            cy        <= (pr.kind == msc_pkg::KIND_TRI) ? pt_y[pr.pc] : '0;
            last_prim <= is_last;
        end
    end

    assign valid = ovld_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid |-> ({1'b0, idx_reg} < ent.count || ent.count == 3'd0))
        else $error("primitive index past case count");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovld_reg && stall) |=> ovld_reg)
        else $error("stalled output word dropped");
    a_take_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_take && has_prims) |=> (ovld_reg && last_prim))
        else $error("cell retired without last primitive");

endmodule

FILE: rtl/marching_squares_cell_unit.sv
// Marching squares cell unit. Each input word is one cell (origin, four corner
// samples); the unit emits that cell's filled triangles and then its contour
// segments, one output word per cycle unless out_stall holds the output
// register, last_prim marking the cell's final one. A cell has 0 to 4
// primitives and holds the pipeline tail until all have gone into the
// single output register. A cell passes 21 registers before its first
// primitive is valid: two stages for the inside test and edge set-up, 16
// stages of the bit-per-stage crossing divider, one offset multiply stage,
// one coordinate stage and the output register. The pipeline advances only
// when its tail may move, so stall loses nothing. Configuration through
// APB: iso_level at 0x0, cell_size at 0x4.
module marching_squares_cell_unit #(
    parameter int SAMPLE_WIDTH = msc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COORD_WIDTH  = msc_pkg::COORD_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [COORD_WIDTH-1:0]  cell_x,
    input  logic [COORD_WIDTH-1:0]  cell_y,
    input  logic [SAMPLE_WIDTH-1:0] sample_0,
    input  logic [SAMPLE_WIDTH-1:0] sample_1,
    input  logic [SAMPLE_WIDTH-1:0] sample_2,
    input  logic [SAMPLE_WIDTH-1:0] sample_3,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    prim_kind,
    output logic [COORD_WIDTH-1:0]  ax,
    output logic [COORD_WIDTH-1:0]  ay,
    output logic [COORD_WIDTH-1:0]  bx,
    output logic [COORD_WIDTH-1:0]  by_coord,
    output logic [COORD_WIDTH-1:0]  cx,
    output logic [COORD_WIDTH-1:0]  cy,
    output logic                    last_prim
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = SW + 1;
    localparam int ZW = msc_pkg::CSIZE_WIDTH;
    localparam int MW = msc_pkg::MU_WIDTH;
    // sideband through the divider: mask + x + y
    localparam int BW = 4 + 2 * CW;

    // ---------------- configuration ----------------
    logic [SW-1:0] iso_reg;
    logic [ZW-1:0] size_reg;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_reg  <= SW'(signed'(msc_pkg::ISO_RESET));
            size_reg <= msc_pkg::SIZE_RESET;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == msc_pkg::REG_ISO)
                iso_reg <= SW'(pwdata);
            else
                size_reg <= pwdata[ZW-1:0];
        end
    end

    always_comb
    begin
        case (paddr[2])
            msc_pkg::REG_ISO:  prdata = 32'(iso_reg);
            msc_pkg::REG_SIZE: prdata = 32'(size_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline enable ----------------
    logic en;
    logic tail_valid, tail_take;
    assign en       = !tail_valid || tail_take;
    assign in_stall = !en;

    // ---------------- stage 1: register inputs, inside test ----------------
    logic          v1_reg;
    logic [CW-1:0] x1_reg, y1_reg;
    logic [SW-1:0] s1_reg [4];
    logic [3:0]    m1_reg;
    logic [3:0]    m_in;

    always_comb
    begin
        m_in[0] = $signed(sample_0) >= $signed(iso_reg);
        m_in[1] = $signed(sample_1) >= $signed(iso_reg);
        m_in[2] = $signed(sample_2) >= $signed(iso_reg);
        m_in[3] = $signed(sample_3) >= $signed(iso_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= cell_x;
            y1_reg    <= cell_y;
            s1_reg[0] <= sample_0;
            s1_reg[1] <= sample_1;
            s1_reg[2] <= sample_2;
            s1_reg[3] <= sample_3;
            m1_reg    <= m_in;
        end
    end

    // ---------------- stage 2: per-edge numerator/denominator ----------------
    // edge e joins corners e and (e+1)&3; inside end is the one with mask bit
    logic          v2_reg;
    logic [CW-1:0] x2_reg, y2_reg;
    logic [3:0]    m2_reg;
    logic [DW-1:0] num2_reg [4];
    logic [DW-1:0] den2_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    genvar e;
    generate
        for (e = 0; e < 4; e++) begin : g_edge
            logic signed [DW-1:0] si, so, lv, nm, dn;
            logic                 ok;
            always_comb
            begin
                si = m1_reg[e] ? DW'($signed(s1_reg[e])) : DW'($signed(s1_reg[(e+1)%4]));
                so = m1_reg[e] ? DW'($signed(s1_reg[(e+1)%4])) : DW'($signed(s1_reg[e]));
                lv = DW'($signed(iso_reg));
                nm = si - lv;
                dn = si - so;
                ok = (dn > 0) && (nm >= 0) && (nm < dn);
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num2_reg[e] <= ok ? nm : '0;
                    den2_reg[e] <= ok ? dn : DW'(1);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            m2_reg <= m1_reg;
        end
    end

    // ---------------- stages 3..18: four dividers ----------------
    logic          dv_vld [4];
    logic [MW-1:0] mu     [4];
    logic [BW-1:0] side_o [4];

    generate
        for (e = 0; e < 4; e++) begin : g_div
            msc_div #(.DW(DW), .SW(BW)) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .in_valid (v2_reg),
                .num      (num2_reg[e]),
                .den      (den2_reg[e]),
                .side_in  ({m2_reg, x2_reg, y2_reg}),
                .out_valid(dv_vld[e]),
                .quo      (mu[e]),
                .side_out (side_o[e])
            );
        end
    endgenerate

    logic [3:0]    m3;
    logic [CW-1:0] x3, y3;
    assign {m3, x3, y3} = side_o[0];

    // ---------------- stage 19: offset multiply ----------------
    logic                v4_reg;
    logic [3:0]          m4_reg;
    logic [CW-1:0]       x4_reg, y4_reg;
    logic [ZW+MW-1:0]    prod4_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= dv_vld[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m4_reg <= m3;
            x4_reg <= x3;
            y4_reg <= y3;
            for (int k = 0; k < 4; k++)
                prod4_reg[k] <= (ZW+MW)'(mu[k]) * (ZW+MW)'(size_reg);
        end
    end

    // ---------------- stage 20: vertex coordinates ----------------
    logic          v5_reg;
    logic [3:0]    m5_reg;
    logic [CW-1:0] px_reg [8];
    logic [CW-1:0] py_reg [8];
    logic [CW-1:0] sz;
    logic [CW-1:0] off [4];
    logic [CW-1:0] px_n [8];
    logic [CW-1:0] py_n [8];

    assign sz = CW'(size_reg);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            off[k] = CW'(prod4_reg[k][ZW+MW-1:MW]);
        px_n[0] = x4_reg;      py_n[0] = y4_reg;
        px_n[1] = x4_reg + sz; py_n[1] = y4_reg;
        px_n[2] = x4_reg + sz; py_n[2] = y4_reg + sz;
        px_n[3] = x4_reg;      py_n[3] = y4_reg + sz;
        // edge 01 along +x from corner 0
        px_n[4] = m4_reg[0] ? x4_reg + off[0] : x4_reg + sz - off[0];
        py_n[4] = y4_reg;
        // edge 12 along +y from corner 1
        px_n[5] = x4_reg + sz;
        py_n[5] = m4_reg[1] ? y4_reg + off[1] : y4_reg + sz - off[1];
        // edge 23 along -x from corner 2
        px_n[6] = m4_reg[2] ? x4_reg + sz - off[2] : x4_reg + off[2];
        py_n[6] = y4_reg + sz;
        // edge 30 along -y from corner 3
        px_n[7] = x4_reg;
        py_n[7] = m4_reg[3] ? y4_reg + sz - off[3] : y4_reg + off[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m5_reg <= m4_reg;
            px_reg <= px_n;
            py_reg <= py_n;
        end
    end

    // ---------------- sequencer ----------------
    assign tail_valid = v5_reg;

    msc_seq #(.COORD_WIDTH(CW)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_valid(v5_reg),
        .cell_take (tail_take),
        .cell_mask (m5_reg),
        .pt_x      (px_reg),
        .pt_y      (py_reg),
        .stall     (out_stall),
        .valid     (out_valid),
        .prim_kind (prim_kind),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by_coord  (by_coord),
        .cx        (cx),
        .cy        (cy),
        .last_prim (last_prim)
    );

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !tail_take) |=> (v5_reg && $stable(m5_reg)))
        else $error("tail cell changed while held");
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v5_reg && !tail_take))
        else $error("input stalled without a held cell");
    a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld[0] == dv_vld[3])
        else $error("divider lanes out of step");

endmodule

FILE: verif/marching_squares_cell_unit_tb.sv
module marching_squares_cell_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    // one expected primitive
    typedef struct {
        logic        kind;
        logic [31:0] ax, ay, bx, by, cx, cy;
        logic        last;
    } prim_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] cell_x, cell_y;
    logic [15:0] sample_0, sample_1, sample_2, sample_3;
    logic        out_valid;
    logic        out_stall;
    logic        prim_kind;
    logic [31:0] ax, ay, bx, by_coord, cx, cy;
    logic        last_prim;

    // shadow of the configuration
    logic signed [15:0] lvl_shadow;
    logic [30:0]        size_shadow;

    prim_word_t prim_queue[$];
    int  mismatches;
    int  cells_sent;
    int  prims_seen;
    int  idle_cycles;
    int  burst_left;
    int  masks_hit[16];

    marching_squares_cell_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .cell_x(cell_x), .cell_y(cell_y),
        .sample_0(sample_0), .sample_1(sample_1),
        .sample_2(sample_2), .sample_3(sample_3),
        .out_valid(out_valid), .out_stall(out_stall),
        .prim_kind(prim_kind), .ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord),
        .cx(cx), .cy(cy), .last_prim(last_prim)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // fan table entry: kind and three point codes
    function automatic logic [9:0] tri3(msc_pkg::pt_code_t a, msc_pkg::pt_code_t b,
                                        msc_pkg::pt_code_t c);
        return {msc_pkg::KIND_TRI, a, b, c};
    endfunction

    function automatic logic [9:0] seg2(msc_pkg::pt_code_t a, msc_pkg::pt_code_t b);
        return {msc_pkg::KIND_SEG, a, b, msc_pkg::P_C0};
    endfunction

    // corner position
    function automatic void corner_pos(int k, logic [31:0] x, logic [31:0] y,
                                       output logic [31:0] px, output logic [31:0] py);
        px = x + ((k == 1 || k == 2) ? {1'b0, size_shadow} : 32'd0);
        py = y + ((k == 2 || k == 3) ? {1'b0, size_shadow} : 32'd0);
    endfunction

    // vertex for a point code: corner, or crossing measured from the inside end
    function automatic void vertex_pos(msc_pkg::pt_code_t code, logic [3:0] mask,
                                       logic [31:0] x, logic [31:0] y,
                                       logic signed [15:0] smp[4],
                                       output logic [31:0] px, output logic [31:0] py);
        int ci, co, ea, eb;
        longint num, den;
        logic [15:0] mu;
        logic [63:0] off;
        logic [31:0] ix, iy, ox, oy;
        if (code < msc_pkg::P_E01)
        begin
            corner_pos(int'(code), x, y, px, py);
            return;
        end
        ea = int'(code) - 4;
        eb = (ea + 1) % 4;
        ci = mask[ea] ? ea : eb;
        co = mask[ea] ? eb : ea;
        num = longint'(smp[ci]) - longint'(lvl_shadow);
        den = longint'(smp[ci]) - longint'(smp[co]);
        mu = 16'd0;
        if (den > 0 && num >= 0 && num < den)
            mu = 16'((num << 16) / den);
        off = (64'(mu) * 64'(size_shadow)) >> 16;
        corner_pos(ci, x, y, ix, iy);
        corner_pos(co, x, y, ox, oy);
        px = ix;
        py = iy;
        if (ox != ix)
            px = (co == 1 || co == 2) ? ix + off[31:0] : ix - off[31:0];
        if (oy != iy)
            py = (co == 2 || co == 3) ? iy + off[31:0] : iy - off[31:0];
    endfunction

    // expected primitives of one cell, appended to the queue
    function automatic void predict_cell(logic [31:0] x, logic [31:0] y,
                                         logic [15:0] s0, logic [15:0] s1,
                                         logic [15:0] s2, logic [15:0] s3);
        logic signed [15:0] smp[4];
        logic [3:0] mask;
        logic [9:0] fan[4];
        int n;
        prim_word_t w;
        smp[0] = s0;
        smp[1] = s1;
        smp[2] = s2;
        smp[3] = s3;
        for (int k = 0; k < 4; k++)
            mask[k] = (smp[k] >= lvl_shadow);
        masks_hit[mask]++;
        n = 2;
        fan[2] = '0;
        fan[3] = '0;
        case (mask)
            4'd0: n = 0;
            4'd1:
            begin
                fan[0] = tri3(msc_pkg::P_C0, msc_pkg::P_E01, msc_pkg::P_E30);
                fan[1] = seg2(msc_pkg::P_E01, msc_pkg::P_E30);
            end
            4'd2:
            begin
                fan[0] = tri3(msc_pkg::P_E01, msc_pkg::P_C1, msc_pkg::P_E12);
                fan[1] = seg2(msc_pkg::P_E01, msc_pkg::P_E12);
            end
            4'd3:
            begin
                n = 3;
                fan[0] = tri3(msc_pkg::P_C0, msc_pkg::P_C1, msc_pkg::P_E30);
                fan[1] = tri3(msc_pkg::P_E30, msc_pkg::P_C1, msc_pkg::P_E12);
                fan[2] = seg2(msc_pkg::P_E30, msc_pkg::P_E12);
            end
            4'd4:
            begin
                fan[0] = tri3(msc_pkg::P_E12, msc_pkg::P_C2, msc_pkg::P_E23);
                fan[1] = seg2(msc_pkg::P_E12, msc_pkg::P_E23);
            end
            4'd5:
            begin
                n = 4;
                fan[0] = tri3(msc_pkg::P_C0, msc_pkg::P_E01, msc_pkg::P_E30);
                fan[1] = tri3(msc_pkg::P_E12, msc_pkg::P_C2, msc_pkg::P_E23);
                fan[2] = seg2(msc_pkg::P_E01, msc_pkg::P_E30);
                fan[3] = seg2(msc_pkg::P_E12, msc_pkg::P_E23);
            end
            4'd6:
            begin
                n = 3;
                fan[0] = tri3(msc_pkg::P_E01, msc_pkg::P_C1, msc_pkg::P_E23);
                fan[1] = tri3(msc_pkg::P_E23, msc_pkg::P_C1, msc_pkg::P_C2);
                fan[2] = seg2(msc_pkg::P_E01, msc_pkg::P_E23);
            end
            4'd7:
            begin
                n = 4;
                fan[0] = tri3(msc_pkg::P_C0, msc_pkg::P_C1, msc_pkg::P_E30);
                fan[1] = tri3(msc_pkg::P_E30, msc_pkg::P_C1, msc_pkg::P_E23);
                fan[2] = tri3(msc_pkg::P_E23, msc_pkg::P_C1, msc_pkg::P_C2);
                fan[3] = seg2(msc_pkg::P_E30, msc_pkg::P_E23);
            end
            4'd8:
            begin
                fan[0] = tri3(msc_pkg::P_E30, msc_pkg::P_E23, msc_pkg::P_C3);
                fan[1] = seg2(msc_pkg::P_E30, msc_pkg::P_E23);
            end
            4'd9:
            begin
                n = 3;
                fan[0] = tri3(msc_pkg::P_C0, msc_pkg::P_E01, msc_pkg::P_C3);
                fan[1] = tri3(msc_pkg::P_C3, msc_pkg::P_E01, msc_pkg::P_E23);
                fan[2] = seg2(msc_pkg::P_E01, msc_pkg::P_E23);
            end
            4'd10:
            begin
                n = 4;
                fan[0] = tri3(msc_pkg::P_E01, msc_pkg::P_C1, msc_pkg::P_E12);
                fan[1] = tri3(msc_pkg::P_E30, msc_pkg::P_E23, msc_pkg::P_C3);
                fan[2] = seg2(msc_pkg::P_E01, msc_pkg::P_E12);
                fan[3] = seg2(msc_pkg::P_E30, msc_pkg::P_E23);
            end
            4'd11:
            begin
                n = 4;
                fan[0] = tri3(msc_pkg::P_C0, msc_pkg::P_C1, msc_pkg::P_E12);
                fan[1] = tri3(msc_pkg::P_C0, msc_pkg::P_E12, msc_pkg::P_E23);
                fan[2] = tri3(msc_pkg::P_C0, msc_pkg::P_E23, msc_pkg::P_C3);
                fan[3] = seg2(msc_pkg::P_E12, msc_pkg::P_E23);
            end
            4'd12:
            begin
                n = 3;
                fan[0] = tri3(msc_pkg::P_E30, msc_pkg::P_E12, msc_pkg::P_C3);
                fan[1] = tri3(msc_pkg::P_C3, msc_pkg::P_E12, msc_pkg::P_C2);
                fan[2] = seg2(msc_pkg::P_E30, msc_pkg::P_E12);
            end
            4'd13:
            begin
                n = 4;
                fan[0] = tri3(msc_pkg::P_C0, msc_pkg::P_E01, msc_pkg::P_C3);
                fan[1] = tri3(msc_pkg::P_C3, msc_pkg::P_E01, msc_pkg::P_E12);
                fan[2] = tri3(msc_pkg::P_C3, msc_pkg::P_E12, msc_pkg::P_C2);
                fan[3] = seg2(msc_pkg::P_E01, msc_pkg::P_E12);
            end
            4'd14:
            begin
                n = 4;
                fan[0] = tri3(msc_pkg::P_E01, msc_pkg::P_C1, msc_pkg::P_C2);
                fan[1] = tri3(msc_pkg::P_E01, msc_pkg::P_C2, msc_pkg::P_E30);
                fan[2] = tri3(msc_pkg::P_E30, msc_pkg::P_C2, msc_pkg::P_C3);
                fan[3] = seg2(msc_pkg::P_E01, msc_pkg::P_E30);
            end
            default:
            begin
                fan[0] = tri3(msc_pkg::P_C0, msc_pkg::P_C1, msc_pkg::P_C3);
                fan[1] = tri3(msc_pkg::P_C3, msc_pkg::P_C1, msc_pkg::P_C2);
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            w.kind = fan[k][9];
            vertex_pos(fan[k][8:6], mask, x, y, smp, w.ax, w.ay);
            vertex_pos(fan[k][5:3], mask, x, y, smp, w.bx, w.by);
            if (w.kind == msc_pkg::KIND_TRI)
                vertex_pos(fan[k][2:0], mask, x, y, smp, w.cx, w.cy);
            else
            begin
                w.cx = '0;
                w.cy = '0;
            end
            w.last = (k == n - 1);
            prim_queue.insert(prim_queue.size(), w);
        end
    endfunction

    // register write, setup then access phase
    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == msc_pkg::REG_ISO)
            lvl_shadow = value[15:0];
        else
            size_shadow = value[30:0];
    endtask

    // pause until every expected word is out and the pipeline is empty
    task automatic drain;
        in_valid <= 1'b0;
        while (prim_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic signed [15:0] lvl, logic [30:0] size);
        drain();
        write_reg(msc_pkg::REG_ISO, {16'h0000, lvl});
        write_reg(msc_pkg::REG_SIZE, {1'b0, size});
    endtask

    // send one cell word, bursts with random gaps
    task automatic send_cell(logic [31:0] x, logic [31:0] y, logic [15:0] s0,
                             logic [15:0] s1, logic [15:0] s2, logic [15:0] s3);
        logic stalled;
        int   gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        cell_x   <= x;
        cell_y   <= y;
        sample_0 <= s0;
        sample_1 <= s1;
        sample_2 <= s2;
        sample_3 <= s3;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        predict_cell(x, y, s0, s1, s2, s3);
        cells_sent++;
    endtask

    // sample near the level so that every inside/outside pattern comes up
    function automatic logic [15:0] rand_sample;
        int v;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        v = int'(lvl_shadow) + $urandom_range(0, 600) - 300;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_cell($urandom, $urandom, rand_sample(), rand_sample(),
                      rand_sample(), rand_sample());
    endtask

    // every case mask at reset settings, plus sample and coordinate extremes
    task automatic test_all_masks;
        for (int m = 0; m < 16; m++)
            send_cell(32'h0001_0000 * m, 32'hFFFF_0000, m[0] ? 16'sd100 : -16'sd50,
                      m[1] ? 16'sd1 : -16'sd1, m[2] ? 16'sd0 : -16'sd30000,
                      m[3] ? 16'sd32767 : -16'sd32768);
        send_cell(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_cell(32'hFFFF_FFFF, 32'h7FFF_0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_cell(32'h8000_0000, 32'h0000_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_cell(32'h0000_0000, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    endtask

    // largest cell size: coordinate sums wrap
    task automatic test_large_cell;
        set_config(16'sd0, 31'h7FFF_FFFF);
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd5, -16'sd5, 16'sd5, -16'sd5);
        send_cell(32'h8000_0000, 32'h4000_0000, 16'sd1000, 16'sd32767, -16'sd1, 16'sd2);
        send_random(60);
    endtask

    // cell size of one, level at the extremes
    task automatic test_level_extremes;
        set_config(-16'sd32768, 31'd1);
        send_cell($urandom, $urandom, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_random(10);
        set_config(16'sd32767, 31'd1);
        send_cell($urandom, $urandom, 16'h7FFF, 16'h8000, 16'h7FFE, 16'h7FFF);
        send_random(40);
    endtask

    task automatic test_random_settings;
        for (int p = 0; p < 4; p++)
        begin
            set_config(16'($urandom), ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                                : 31'($urandom_range(1, 1 << 20)));
            send_random(37);
        end
    endtask

    // receiver stall pattern: free, light, heavy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            case ((cells_sent / 23) % 3)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
    end

    // compare each accepted output word with the oldest expectation
    always @(negedge clk)
    begin
        prim_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            prims_seen++;
            if (prim_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word kind=%0d a=(%h,%h)", prim_kind, ax, ay);
            end
            else
            begin
                w = prim_queue.pop_front();
                if (prim_kind !== w.kind || ax !== w.ax || ay !== w.ay || bx !== w.bx
                    || by_coord !== w.by || cx !== w.cx || cy !== w.cy
                    || last_prim !== w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp k=%0d a=(%h,%h) b=(%h,%h) c=(%h,%h) l=%0d",
                                 w.kind, w.ax, w.ay, w.bx, w.by, w.cx, w.cy, w.last);
                        $display("         got k=%0d a=(%h,%h) b=(%h,%h) c=(%h,%h) l=%0d",
                                 prim_kind, ax, ay, bx, by_coord, cx, cy, last_prim);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted word on either side and no register access
    always @(negedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int masks_covered;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        cell_x = '0;
        cell_y = '0;
        sample_0 = '0;
        sample_1 = '0;
        sample_2 = '0;
        sample_3 = '0;
        lvl_shadow = msc_pkg::ISO_RESET;
        size_shadow = msc_pkg::SIZE_RESET;
        mismatches = 0;
        cells_sent = 0;
        prims_seen = 0;
        idle_cycles = 0;
        burst_left = 0;
        foreach (masks_hit[m])
            masks_hit[m] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_all_masks();
        send_random(50);
        test_large_cell();
        test_level_extremes();
        test_random_settings();
        drain();

        masks_covered = 0;
        foreach (masks_hit[m])
            if (masks_hit[m] != 0)
                masks_covered++;
        $display("cells sent %0d, primitives checked %0d, case masks seen %0d of 16",
                 cells_sent, prims_seen, masks_covered);
        $display("levels and cell sizes swept to both extremes, with wrapping coordinates");
        if (mismatches == 0 && prim_queue.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: files.f
rtl/msc_pkg.sv
rtl/msc_div.sv
rtl/msc_seq.sv
rtl/marching_squares_cell_unit.sv
verif/marching_squares_cell_unit_tb.sv
